// ===== src/biquad_pkg.sv =====
// biquad_pkg: widths, register indexes, command codes and fixed-point helpers
// for the saturating direct form II biquad. No dependencies.
package biquad_pkg;

	localparam int SAMPLE_BITS   = 9;
	localparam int COEF_BITS     = 9;
	localparam int W_BITS        = 10;
	localparam int ACC_BITS      = 8;
	localparam int PRODUCT_BITS  = 18;
	localparam int PRODUCT_SHIFT = 10;
	localparam int OPC_BITS      = COEF_BITS + 1;
	localparam int MUL_BITS      = W_BITS + OPC_BITS;
	localparam int CFG_IDX_BITS  = 3;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [OPC_BITS-1:0]    opc_t;
	typedef logic signed [W_BITS-1:0]      w_t;
	typedef logic signed [ACC_BITS-1:0]    acc_t;
	typedef logic signed [MUL_BITS-1:0]    mul_t;
	typedef logic signed [PRODUCT_BITS-1:0] prod_t;
	typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;
	typedef logic [2:0]                    mul_sel_t;

	// register indexes
	localparam cfg_idx_t REG_B0 = 3'd0;
	localparam cfg_idx_t REG_B1 = 3'd1;
	localparam cfg_idx_t REG_B2 = 3'd2;
	localparam cfg_idx_t REG_A1 = 3'd3;
	localparam cfg_idx_t REG_A2 = 3'd4;

	localparam coef_t B0_RST = 9'sd52;
	localparam coef_t B1_RST = 9'sd105;
	localparam coef_t B2_RST = 9'sd52;
	localparam coef_t A1_RST = -9'sd95;
	localparam coef_t A2_RST = 9'sd50;

	// multiplier operand select
	localparam mul_sel_t MUL_FB1 = 3'd0;
	localparam mul_sel_t MUL_FF1 = 3'd1;
	localparam mul_sel_t MUL_FB2 = 3'd2;
	localparam mul_sel_t MUL_FF2 = 3'd3;
	localparam mul_sel_t MUL_W0  = 3'd4;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_fb;
		logic     acc_ff;
		logic     w_en;
		logic     y_en;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	// saturate a product to PRODUCT_BITS, then arithmetic shift right
	function automatic acc_t scale_prod(input mul_t p);
		prod_t ps;
		if (p > mul_t'((1 <<< (PRODUCT_BITS-1)) - 1))
			ps = prod_t'((1 <<< (PRODUCT_BITS-1)) - 1);
		else if (p < -mul_t'(1 <<< (PRODUCT_BITS-1)))
			ps = prod_t'(-(1 <<< (PRODUCT_BITS-1)));
		else
			ps = p[PRODUCT_BITS-1:0];
		return ps[PRODUCT_BITS-1:PRODUCT_SHIFT];
	endfunction

	function automatic acc_t acc_add(input acc_t a, input acc_t b);
		logic signed [ACC_BITS:0] s;
		s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
		if (s > 9'sd127)
			return 8'sd127;
		else if (s < -9'sd128)
			return -8'sd128;
		else
			return s[ACC_BITS-1:0];
	endfunction

	// w = sat10(x + fb*4)
	function automatic w_t w_calc(input sample_t x, input acc_t fb);
		logic signed [10:0] s;
		s = {{2{x[SAMPLE_BITS-1]}}, x} + {fb[ACC_BITS-1], fb, 2'b00};
		if (s > 11'sd511)
			return 10'sd511;
		else if (s < -11'sd512)
			return -10'sd512;
		else
			return s[W_BITS-1:0];
	endfunction

	// y = sat9((p + ff) * 4)
	function automatic sample_t y_calc(input acc_t p, input acc_t ff);
		logic signed [ACC_BITS:0] s;
		s = {p[ACC_BITS-1], p} + {ff[ACC_BITS-1], ff};
		if (s > 9'sd63)
			return 9'sd255;
		else if (s < -9'sd64)
			return -9'sd256;
		else
			return {s[6:0], 2'b00};
	endfunction

endpackage

// ===== src/biquad_ifs.sv =====
// biquad_ifs: valid/ready stream interfaces for input and output samples
// depends on biquad_pkg
interface biquad_in_if;
	import biquad_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample_in;
	modport source(output valid, output sample_in, input ready);
	modport sink(input valid, input sample_in, output ready);
endinterface

interface biquad_out_if;
	import biquad_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample_out;
	modport source(output valid, output sample_out, input ready);
	modport sink(input valid, input sample_out, output ready);
endinterface

// ===== src/biquad_iir_df2_saturating_top.sv =====
// channel      dir  payload            handshake
// sample_ch    in   sample_in  s9      valid/ready
// filtered_ch  out  sample_out s9      valid/ready
// cfg          in   cfg_index, cfg_data  cfg_we, no back-pressure
//
// after acceptance, a sample passes through the product steps FB1, FF1, FB2, FF2 and W; the
// shared 10x10 multiplier runs five products back to back, then the output step
// the next sample can be taken in the output step, so back-to-back words need no idle step
// a stalled output holds the sequencer in its output step; the following sample
// still waits in the input handshake until the output register frees up
// reset clears the delay line, accumulators, output valid and loads default coefficients
// depends on biquad_pkg, biquad_ifs, biquad_ctrl, biquad_dp
module biquad_iir_df2_saturating_top (
	input  logic                 clk,
	input  logic                 arst_n,
	biquad_in_if.sink            sample_ch,
	biquad_out_if.source         filtered_ch,
	input  logic                 cfg_we,
	input  biquad_pkg::cfg_idx_t cfg_index,
	input  biquad_pkg::coef_t    cfg_data
);
	import biquad_pkg::*;

	cmd_t    cmd;
	status_t status;

	biquad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (sample_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	biquad_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (sample_ch.sample_in),
		.sample_out (filtered_ch.sample_out),
		.out_valid  (filtered_ch.valid),
		.out_ready  (filtered_ch.ready),
		.cmd        (cmd),
		.status     (status)
	);

endmodule

// ===== src/biquad_ctrl.sv =====
// biquad_ctrl: sequencer that steps the shared multiplier through the five
// products of one sample; depends on biquad_pkg
module biquad_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  biquad_pkg::status_t status,
	output biquad_pkg::cmd_t    cmd
);
	import biquad_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FB1  = 3'd1;
	localparam logic [2:0] ST_FF1  = 3'd2;
	localparam logic [2:0] ST_FB2  = 3'd3;
	localparam logic [2:0] ST_FF2  = 3'd4;
	localparam logic [2:0] ST_W    = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE) || (state_q == ST_OUT && !status.out_busy);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.load    = accept;
		cmd.mul_sel = MUL_FB1;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_FB1;
			end
			ST_FB1: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_FF1;
			end
			ST_FF1: begin
				cmd.acc_fb  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_FF1;
				state_d     = ST_FB2;
			end
			ST_FB2: begin
				cmd.acc_ff  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_FB2;
				state_d     = ST_FF2;
			end
			ST_FF2: begin
				cmd.acc_fb  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_FF2;
				state_d     = ST_W;
			end
			ST_W: begin
				// fb is final here: new w feeds the multiplier and the delay line
				cmd.acc_ff  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_W0;
				cmd.w_en    = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (!status.out_busy) begin
					cmd.y_en = 1'b1;
					state_d  = accept ? ST_FB1 : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_FB1)
		else $error("accepted word did not start a pass");
	a_w_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.w_en |=> state_q == ST_OUT)
		else $error("w update not followed by output step");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.y_en |-> !status.out_busy)
		else $error("output register written while busy");
	a_one_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.acc_fb, cmd.acc_ff, cmd.y_en}))
		else $error("conflicting accumulate commands");
`endif

endmodule

// ===== src/biquad_dp.sv =====
// biquad_dp: coefficient registers, delay line, shared multiplier,
// saturating accumulators and output register; depends on biquad_pkg
module biquad_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  biquad_pkg::cfg_idx_t   cfg_index,
	input  biquad_pkg::coef_t      cfg_data,
	input  biquad_pkg::sample_t    sample_in,
	output biquad_pkg::sample_t    sample_out,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  biquad_pkg::cmd_t       cmd,
	output biquad_pkg::status_t    status
);
	import biquad_pkg::*;

	coef_t   b0_q, b1_q, b2_q, a1_q, a2_q;
	w_t      w1_q, w2_q;
	sample_t x_q;
	acc_t    fb_q, ff_q;
	mul_t    prod_q;
	sample_t y_q;
	logic    out_valid_q;

	w_t      w_new;
	w_t      op_w;
	opc_t    op_c;
	mul_t    mul_res;
	acc_t    prod_scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= B0_RST;
			b1_q <= B1_RST;
			b2_q <= B2_RST;
			a1_q <= A1_RST;
			a2_q <= A2_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_B0:  b0_q <= cfg_data;
				REG_B1:  b1_q <= cfg_data;
				REG_B2:  b2_q <= cfg_data;
				REG_A1:  a1_q <= cfg_data;
				REG_A2:  a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_new = w_calc(x_q, fb_q);

	// feedback taps use the negated a coefficient
	always_comb begin
		case (cmd.mul_sel)
			MUL_FB1: begin
				op_w = w1_q;
				op_c = opc_t'(0) - {a1_q[COEF_BITS-1], a1_q};
			end
			MUL_FF1: begin
				op_w = w1_q;
				op_c = {b1_q[COEF_BITS-1], b1_q};
			end
			MUL_FB2: begin
				op_w = w2_q;
				op_c = opc_t'(0) - {a2_q[COEF_BITS-1], a2_q};
			end
			MUL_FF2: begin
				op_w = w2_q;
				op_c = {b2_q[COEF_BITS-1], b2_q};
			end
			default: begin
				op_w = w_new;
				op_c = {b0_q[COEF_BITS-1], b0_q};
			end
		endcase
	end

	assign mul_res     = mul_t'(op_w) * mul_t'(op_c);
	assign prod_scaled = scale_prod(prod_q);

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= mul_res;
		if (cmd.load)
			x_q <= sample_in;
		if (cmd.y_en)
			y_q <= y_calc(prod_scaled, ff_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_q        <= '0;
			w2_q        <= '0;
			fb_q        <= '0;
			ff_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.w_en) begin
				w1_q <= w_new;
				w2_q <= w1_q;
			end
			if (cmd.load)
				fb_q <= '0;
			else if (cmd.acc_fb)
				fb_q <= acc_add(fb_q, prod_scaled);
			if (cmd.load)
				ff_q <= '0;
			else if (cmd.acc_ff)
				ff_q <= acc_add(ff_q, prod_scaled);
			if (cmd.y_en)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign sample_out      = y_q;
	assign out_valid       = out_valid_q;
	assign status.out_busy = out_valid_q && !out_ready;

`ifndef SYNTHESIS
	a_y_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.y_en |=> out_valid_q)
		else $error("output word not marked valid");
	a_delay_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.w_en |=> w2_q == $past(w1_q))
		else $error("delay line did not shift");
	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> fb_q == '0 && ff_q == '0)
		else $error("accumulators not cleared at start");
`endif

endmodule
